FILE: hw/rtl/look_at_view_matrix_top_assert.svh
// Assertion macros shared by the look-at view matrix RTL.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH

// Same-cycle implication.
`define LAVM_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lavm: same-cycle check failed");

// Next-cycle implication.
`define LAVM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lavm: next-cycle check failed");

`endif

FILE: hw/rtl/lavm_pkg.sv
// Types and constants for the look-at view matrix block.
// No dependencies.
`default_nettype none

package lavm_pkg;

  localparam int COORD_W = 32;
  localparam int IN_W    = 9 * COORD_W;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic [1:0] ROW_LEFT = 2'd0;
  localparam logic [1:0] ROW_UP   = 2'd1;
  localparam logic [1:0] ROW_FWD  = 2'd2;

  // One camera item as queued between front and back.
  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][32:0] dif;
    logic [2:0][31:0] upw;
  } cam_t;

  // One result row.
  typedef struct packed {
    logic [1:0]  row_index;
    logic [31:0] axis_x;
    logic [31:0] axis_y;
    logic [31:0] axis_z;
    logic [31:0] offset;
    logic        last_row;
    logic        degenerate;
  } row_t;

endpackage

`default_nettype wire

FILE: hw/rtl/look_at_view_matrix_top.sv
// Look-at view matrix: top level with the output register.
// Depends on lavm_pkg, lavm_front and lavm_back.
`default_nettype none

// From input word to first row an item passes the normalize shift steps, the
//   square root and the divide for each vector; a zero-length vector skips its
//   square root and divide.
// The back end takes one camera item per run and emits its three rows; a two-entry
//   queue takes further items while the back end is busy.
// Reset: rst, synchronous, active high; clears queue, sequencer and out valid.
module look_at_view_matrix_top import lavm_pkg::*; #(
  parameter int AXIS_FRAC_BITS = 30
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  // eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, upward_x, upward_y, upward_z
  input  wire logic [IN_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  // axis_x, axis_y, axis_z, offset
  output logic [127:0]         m_tdata,
  // row_index [1:0], degenerate [2]
  output logic [2:0]           m_tuser,
  output logic                 m_tlast
);

  logic q_valid;
  logic q_pop;
  cam_t q_data;
  logic emit_valid;
  logic emit_ready;
  row_t emit_row;
  row_t out_row;

  lavm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  lavm_back #(
    .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .emit_valid (emit_valid),
    .emit_row   (emit_row),
    .emit_ready (emit_ready)
  );

  // Output register: load whenever empty or being drained.
  assign emit_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_ready) begin
      m_tvalid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit_valid) begin
      out_row <= emit_row;
    end
  end

  assign m_tdata = {out_row.offset, out_row.axis_z, out_row.axis_y, out_row.axis_x};
  assign m_tuser = {out_row.degenerate, out_row.row_index};
  assign m_tlast = out_row.last_row;

endmodule

`default_nettype wire

FILE: hw/rtl/lavm_front.sv
// Front end: accepts camera words, forms eye - aim and queues the item.
// Depends on lavm_pkg and look_at_view_matrix_top_assert.svh.
`default_nettype none

module lavm_front import lavm_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [IN_W-1:0] s_tdata,
  input  wire logic            q_pop,
  output logic                 q_valid,
  output cam_t                 q_data
);

  cam_t                entry [QDEPTH];
  cam_t                incoming;
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     qcount;
  logic                push;
  logic                pop;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      incoming.eye[i] = s_tdata[32*i +: 32];
      incoming.upw[i] = s_tdata[192 + 32*i +: 32];
      incoming.dif[i] = {s_tdata[32*i + 31], s_tdata[32*i +: 32]}
                      - {s_tdata[96 + 32*i + 31], s_tdata[96 + 32*i +: 32]};
    end
  end

  assign s_tready = (qcount != (QPTR_W+1)'(QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (qcount != '0);
  assign pop      = q_pop && q_valid;
  assign q_data   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      qcount <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      qcount <= qcount + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

`include "look_at_view_matrix_top_assert.svh"

  `LAVM_ASSERT(a_q_bound, 1'b1, qcount <= (QPTR_W+1)'(QDEPTH))
  `LAVM_ASSERT_NEXT(a_q_push_seen, push && !q_valid, q_valid)

endmodule

`default_nettype wire

FILE: hw/rtl/lavm_back.sv
// Back end: sequencer with one shared multiplier, square root and divide
// loops; builds the three axes, their offsets and emits rows.
// Depends on lavm_pkg and look_at_view_matrix_top_assert.svh.
`default_nettype none

module lavm_back import lavm_pkg::*; #(
  parameter int AXIS_FRAC_BITS = 30
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire cam_t q_data,
  output logic      q_pop,
  output logic      emit_valid,
  output row_t      emit_row,
  input  wire logic emit_ready
);

  localparam int QW = AXIS_FRAC_BITS + 1;
  localparam int NW = 32 + AXIS_FRAC_BITS;

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_ABS   = 4'd1;
  localparam logic [3:0] ST_SHIFT = 4'd2;
  localparam logic [3:0] ST_SQ    = 4'd3;
  localparam logic [3:0] ST_SQRT  = 4'd4;
  localparam logic [3:0] ST_DIVI  = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_STORE = 4'd7;
  localparam logic [3:0] ST_CROSS = 4'd8;
  localparam logic [3:0] ST_DOT   = 4'd9;
  localparam logic [3:0] ST_RND   = 4'd10;
  localparam logic [3:0] ST_EMIT  = 4'd11;

  localparam logic [1:0] NV_FWD = 2'd0;
  localparam logic [1:0] NV_LFT = 2'd1;
  localparam logic [1:0] NV_UP  = 2'd2;

  localparam logic [63:0]        SQRT_BIT0 = 64'h4000_0000_0000_0000;
  localparam logic signed [66:0] RND_HALF  = 67'sd1 <<< (AXIS_FRAC_BITS - 1);
  localparam logic signed [66:0] SAT_HI    = 67'sd2147483647;
  localparam logic signed [66:0] SAT_LO    = -67'sd2147483648;

  function automatic logic [1:0] nxt(input logic [1:0] j);
    nxt = (j == 2'd2) ? 2'd0 : j + 2'd1;
  endfunction

  logic [3:0]              state;
  logic [1:0]              stage;
  logic [2:0]              k;
  logic [5:0]              it;
  logic [1:0]              row;
  logic                    deg;
  logic [2:0][31:0]        eye;
  logic [2:0][31:0]        upw;
  logic signed [63:0]      vec [3];
  logic [62:0]             mag [3];
  logic [2:0]              neg;
  logic [2:0][31:0]        axis_fwd;
  logic [2:0][31:0]        axis_lft;
  logic [2:0][31:0]        axis_up;
  logic signed [63:0]      prod;
  logic [63:0]             acc;
  logic [63:0]             sr;
  logic [63:0]             sbit;
  logic [31:0]             len;
  logic [31:0]             rem [3];
  logic [QW-1:0]           num [3];
  logic [QW-1:0]           quo [3];
  logic signed [65:0]      dacc;
  logic [31:0]             offs [3];

  logic signed [31:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic [2:0][31:0]        cra;
  logic [2:0][31:0]        crb;
  logic [2:0][31:0]        dot_axis;
  logic [1:0]              cj;
  logic [1:0]              ci1;
  logic [1:0]              ci2;
  logic [1:0]              pj;
  logic                    nz_hi;
  logic                    nz_top;
  logic                    vec_zero;
  logic [63:0]             sq_t;
  logic [NW-1:0]           nval [3];
  logic [32:0]             dv_t [3];
  logic                    dv_ge [3];
  logic [31:0]             axv [3];
  logic signed [66:0]      rnd_v;
  logic signed [66:0]      rnd_s;
  logic [31:0]             rnd_sat;

  // Operand routing for the shared multiplier.
  always_comb begin
    cra = (stage == NV_FWD) ? upw : axis_fwd;
    crb = (stage == NV_FWD) ? axis_fwd : axis_lft;
    unique case (row)
      ROW_LEFT: dot_axis = axis_lft;
      ROW_UP:   dot_axis = axis_up;
      default:  dot_axis = axis_fwd;
    endcase
    cj  = k[2:1];
    ci1 = nxt(cj);
    ci2 = nxt(nxt(cj));
    pj  = 2'((k - 3'd1) >> 1);
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQ: begin
        if (k < 3'd3) begin
          mul_a = {1'b0, mag[k[1:0]][30:0]};
          mul_b = {1'b0, mag[k[1:0]][30:0]};
        end
      end
      ST_CROSS: begin
        if (k < 3'd6) begin
          mul_a = k[0] ? cra[ci2] : cra[ci1];
          mul_b = k[0] ? crb[ci1] : crb[ci2];
        end
      end
      ST_DOT: begin
        if (k < 3'd3) begin
          mul_a = dot_axis[k[1:0]];
          mul_b = eye[k[1:0]];
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    nz_hi    = (|mag[0][62:31]) | (|mag[1][62:31]) | (|mag[2][62:31]);
    nz_top   = mag[0][30] | mag[1][30] | mag[2][30];
    vec_zero = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
    sq_t     = sr + sbit;
    for (int i = 0; i < 3; i++) begin
      nval[i]  = NW'({mag[i][30:0], {AXIS_FRAC_BITS{1'b0}}}) + NW'(sr[31:1]);
      dv_t[i]  = {rem[i], num[i][QW-1]};
      dv_ge[i] = dv_t[i] >= {1'b0, len};
      axv[i]   = neg[i] ? (32'd0 - 32'(quo[i])) : 32'(quo[i]);
    end
    rnd_v = RND_HALF - dacc;
    rnd_s = rnd_v >>> AXIS_FRAC_BITS;
    if (rnd_s > SAT_HI) begin
      rnd_sat = 32'h7FFF_FFFF;
    end else if (rnd_s < SAT_LO) begin
      rnd_sat = 32'h8000_0000;
    end else begin
      rnd_sat = rnd_s[31:0];
    end
  end

  assign q_pop      = (state == ST_LOAD) && q_valid;
  assign emit_valid = (state == ST_EMIT);

  always_comb begin
    emit_row.row_index  = row;
    emit_row.axis_x     = dot_axis[0];
    emit_row.axis_y     = dot_axis[1];
    emit_row.axis_z     = dot_axis[2];
    emit_row.offset     = offs[row];
    emit_row.last_row   = (row == ROW_FWD);
    emit_row.degenerate = deg;
  end

  // Multiplier output register, free running.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      stage <= NV_FWD;
      k     <= '0;
      it    <= '0;
      row   <= ROW_LEFT;
      deg   <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (q_valid) begin
            eye   <= q_data.eye;
            upw   <= q_data.upw;
            for (int i = 0; i < 3; i++) begin
              vec[i] <= 64'($signed(q_data.dif[i]));
            end
            stage <= NV_FWD;
            deg   <= 1'b0;
            state <= ST_ABS;
          end
        end
        ST_ABS: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= vec[i][63];
            mag[i] <= vec[i][63] ? 63'(-vec[i]) : vec[i][62:0];
            quo[i] <= '0;
          end
          if (vec_zero) begin
            deg   <= 1'b1;
            state <= ST_STORE;
          end else begin
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          // Bring the largest magnitude into [2^30, 2^31).
          if (nz_hi) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (!nz_top) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            k     <= '0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (k == 3'd0) begin
            acc <= '0;
          end else begin
            acc <= acc + 64'(prod);
          end
          if (k == 3'd3) begin
            sr    <= '0;
            sbit  <= SQRT_BIT0;
            it    <= '0;
            state <= ST_SQRT;
          end else begin
            k <= k + 3'd1;
          end
        end
        ST_SQRT: begin
          if (acc >= sq_t) begin
            acc <= acc - sq_t;
            sr  <= (sr >> 1) + sbit;
          end else begin
            sr  <= sr >> 1;
          end
          sbit <= sbit >> 2;
          if (it == 6'd31) begin
            state <= ST_DIVI;
          end else begin
            it <= it + 6'd1;
          end
        end
        ST_DIVI: begin
          len <= sr[31:0];
          for (int i = 0; i < 3; i++) begin
            rem[i] <= {1'b0, nval[i][NW-1:QW]};
            num[i] <= nval[i][QW-1:0];
          end
          it    <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= dv_ge[i] ? 32'(dv_t[i] - {1'b0, len}) : dv_t[i][31:0];
            num[i] <= num[i] << 1;
            quo[i] <= {quo[i][QW-2:0], dv_ge[i]};
          end
          if (it == 6'(QW - 1)) begin
            state <= ST_STORE;
          end else begin
            it <= it + 6'd1;
          end
        end
        ST_STORE: begin
          unique case (stage)
            NV_FWD:  axis_fwd <= {axv[2], axv[1], axv[0]};
            NV_LFT:  axis_lft <= {axv[2], axv[1], axv[0]};
            default: axis_up  <= {axv[2], axv[1], axv[0]};
          endcase
          k <= '0;
          if (stage == NV_UP) begin
            row   <= ROW_LEFT;
            state <= ST_DOT;
          end else begin
            state <= ST_CROSS;
          end
        end
        ST_CROSS: begin
          // Even product opens a component, odd product subtracts from it.
          if (k != 3'd0) begin
            if (!k[0]) begin
              vec[pj] <= vec[pj] - prod;
            end else begin
              vec[pj] <= prod;
            end
          end
          if (k == 3'd6) begin
            stage <= stage + 2'd1;
            state <= ST_ABS;
          end else begin
            k <= k + 3'd1;
          end
        end
        ST_DOT: begin
          if (k == 3'd0) begin
            dacc <= '0;
          end else begin
            dacc <= dacc + prod;
          end
          if (k == 3'd3) begin
            state <= ST_RND;
          end else begin
            k <= k + 3'd1;
          end
        end
        ST_RND: begin
          offs[row] <= rnd_sat;
          k         <= '0;
          if (row == ROW_FWD) begin
            row   <= ROW_LEFT;
            state <= ST_EMIT;
          end else begin
            row   <= row + 2'd1;
            state <= ST_DOT;
          end
        end
        ST_EMIT: begin
          if (emit_ready) begin
            if (row == ROW_FWD) begin
              row   <= ROW_LEFT;
              state <= ST_LOAD;
            end else begin
              row <= row + 2'd1;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

`include "look_at_view_matrix_top_assert.svh"

  `LAVM_ASSERT(a_norm_range, state == ST_SQ && k == 3'd0, nz_top && !nz_hi)
  `LAVM_ASSERT(a_len_range, state == ST_DIVI, sr[63:32] == '0 && sr[31:30] != 2'b00)
  `LAVM_ASSERT(a_div_rem, state == ST_DIV, rem[0] < len && rem[1] < len && rem[2] < len)

endmodule

`default_nettype wire
